@@ design/chained_hash_table_defines.svh @@
// Assertion macros shared by the chained hash table RTL
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/cht_pkg.sv @@
// Package: sizes, status codes and commands of the chained hash table
package cht_pkg;
    localparam int unsigned BUCKETS_DEF    = 10;
    localparam int unsigned POOL_NODES_DEF = 64;
    localparam int unsigned KEY_W = 31;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned ST_W  = 3;
    localparam int unsigned BKT_W = 4;
    localparam int unsigned POS_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd5;
endpackage

@@ design/cht_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module cht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/chained_hash_table.sv @@
// Top level: chained hash table with a node pool walked by one sequencer
//
// Commands are taken while busy is low. The key is reduced modulo BUCKETS by a
// reciprocal multiply, a multiply-subtract and one correcting compare, in the
// states S_MOD, S_MOD_Q and S_MOD_FIX. Each command then walks its bucket chain
// one node at a time through a single node memory read port, each node visit
// passing through S_RD, S_WAIT and S_CHECK. Search or delete stops at its match
// (a delete that relinks a predecessor adds a link write); a miss walks the
// whole chain, and an empty bucket is answered without a walk. Insert scans the
// free-node bitmap one node per cycle and takes the lowest free node; on a
// non-empty bucket it then walks to the tail and links the new node there, and
// a full pool answers ST_FULL. One result appears per insert/search/delete for
// a single cycle on o_valid, in the cycle busy drops; the receiver cannot hold
// it off. Command code 3 gives no result.
`include "chained_hash_table_defines.svh"
module chained_hash_table #(
    parameter int unsigned BUCKETS    = cht_pkg::BUCKETS_DEF,
    parameter int unsigned POOL_NODES = cht_pkg::POOL_NODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [cht_pkg::CMD_W-1:0]  i_cmd,
    input  logic [cht_pkg::KEY_W-1:0]  i_item_key,
    input  logic signed [cht_pkg::VAL_W-1:0] i_item_value,
    output logic                       o_valid,
    output logic [cht_pkg::ST_W-1:0]   o_status,
    output logic [cht_pkg::BKT_W-1:0]  o_bucket,
    output logic signed [cht_pkg::VAL_W-1:0] o_found_value,
    output logic [cht_pkg::POS_W-1:0]  o_chain_position
);
    import cht_pkg::*;

    localparam int unsigned NW = $clog2(POOL_NODES + 1);
    localparam int unsigned NA = $clog2(POOL_NODES);
    localparam int unsigned BW = $clog2(BUCKETS);
    localparam int unsigned RW = $clog2(BUCKETS) + 1;
    localparam int unsigned PRW = KEY_W + 32;
    localparam int unsigned PW = $clog2(POOL_NODES + 2);
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
    localparam int unsigned MW = KEY_W + VAL_W + NW;
    // floor(2^32 / BUCKETS): quotient estimate is exact or one low
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_MOD_Q, S_MOD_FIX, S_DISPATCH, S_FREE, S_RD, S_WAIT,
        S_CHECK, S_LINK_WR, S_DONE
    } t_state;

    t_state r_state;
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [RW-1:0]    r_rem;
    logic [PRW-1:0]   r_prod;
    logic [KEY_W-1:0] r_diff;
    logic [NW-1:0]    r_head [BUCKETS];
    logic [POOL_NODES-1:0] r_used;
    logic [NW-1:0]    r_cur, r_prev, r_fresh, r_scan;
    logic [KEY_W-1:0] r_pkey;
    logic [VAL_W-1:0] r_pval;
    logic [PW-1:0]    r_pos;
    logic             r_valid;
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_fval;
    logic [POS_W-1:0] r_opos;

    logic            m_we;
    logic [NA-1:0]   m_waddr, m_raddr;
    logic [MW-1:0]   m_wdata, m_rdata;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic [NW-1:0]    rd_link;
    logic [BW-1:0]    bkt;

    assign rd_key  = m_rdata[MW-1 -: KEY_W];
    assign rd_val  = m_rdata[NW +: VAL_W];
    assign rd_link = m_rdata[NW-1:0];
    assign bkt     = r_rem[BW-1:0];

    cht_ram #(.WIDTH(MW), .DEPTH(POOL_NODES)) u_nodes (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    // memory write: new node on insert, link rewrite on tail append/delete
    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_fresh[NA-1:0];
        m_wdata = {r_key, r_val, NIL};
        m_raddr = r_cur[NA-1:0];
        if (r_state == S_FREE && r_used[r_scan[NA-1:0]] == 1'b0
            && r_scan != NIL) begin
            m_we    = 1'b1;
            m_waddr = r_scan[NA-1:0];
        end else if (r_state == S_LINK_WR) begin
            m_we    = 1'b1;
            m_waddr = r_prev[NA-1:0];
            m_wdata = {r_pkey, r_pval, (r_cmd == CMD_INSERT) ? r_fresh : r_cur};
        end
    end

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= NIL;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start && i_cmd != CMD_NOP) begin
                        r_cmd   <= i_cmd;
                        r_key   <= i_item_key;
                        r_val   <= i_item_value;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_prod  <= PRW'(r_key) * PRW'(RECIP);
                    r_state <= S_MOD_Q;
                end
                S_MOD_Q: begin
                    r_diff  <= r_key - r_prod[PRW-1:32] * KEY_W'(BUCKETS);
                    r_state <= S_MOD_FIX;
                end
                S_MOD_FIX: begin
                    r_rem   <= (r_diff >= KEY_W'(BUCKETS)) ? RW'(r_diff - KEY_W'(BUCKETS))
                                                         : RW'(r_diff);
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_cur   <= r_head[bkt];
                    r_prev  <= NIL;
                    r_pos   <= PW'(1);
                    r_fval  <= '0;
                    r_opos  <= '0;
                    r_scan  <= '0;
                    if (r_cmd == CMD_INSERT) begin
                        r_state <= S_FREE;
                    end else if (r_head[bkt] == NIL) begin
                        r_status <= (r_cmd == CMD_DELETE) ? ST_EMPTY : ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_FREE: begin
                    if (r_scan == NIL) begin
                        r_status <= ST_FULL;
                        r_state  <= S_DONE;
                    end else if (!r_used[r_scan[NA-1:0]]) begin
                        r_used[r_scan[NA-1:0]] <= 1'b1;
                        r_fresh  <= r_scan;
                        r_status <= ST_INSERTED;
                        if (r_cur == NIL) begin
                            r_head[bkt] <= r_scan;
                            r_state     <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_RD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_cmd == CMD_INSERT) begin
                        if (rd_link < NIL && r_pos <= PW'(POOL_NODES)) begin
                            r_cur   <= rd_link;
                            r_pos   <= r_pos + 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_prev  <= r_cur;
                            r_pkey  <= rd_key;
                            r_pval  <= rd_val;
                            r_cur   <= r_fresh;
                            r_state <= S_LINK_WR;
                        end
                    end else if (rd_key == r_key) begin
                        r_opos <= POS_W'(r_pos);
                        if (r_cmd == CMD_SEARCH) begin
                            r_status <= ST_FOUND;
                            r_fval   <= rd_val;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_DELETED;
                            r_used[r_cur[NA-1:0]] <= 1'b0;
                            if (r_prev == NIL) begin
                                r_head[bkt] <= rd_link;
                                r_state     <= S_DONE;
                            end else begin
                                r_cur   <= rd_link;
                                r_state <= S_LINK_WR;
                            end
                        end
                    end else if (rd_link < NIL && r_pos < PW'(POOL_NODES)) begin
                        r_prev  <= r_cur;
                        r_pkey  <= rd_key;
                        r_pval  <= rd_val;
                        r_cur   <= rd_link;
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end
                end
                S_LINK_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_bucket         = BKT_W'(r_rem);
    assign o_found_value    = r_fval;
    assign o_chain_position = r_opos;

    `CHT_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, r_state == S_DISPATCH, r_rem < RW'(BUCKETS))
    `CHT_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, r_valid && !busy)
    `CHT_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
endmodule
